// ===== sv/rbba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbba_pkg
// Types and constants shared by the rotated box bounds accumulator.
// ----------------------------------------------------------------------------
package rbba_pkg;

  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [1:0] {
    CMD_BOX    = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_Z_ALT = 2'd3
  } axis_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = -24'sh800000;

  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
  localparam logic signed [33:0] DEG_SCALE = 34'sd240315917;

  // atan(2^-i) in units of 2^-22 degree
  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd188743680;
      5'd1: r = 34'sd111421900;
      5'd2: r = 34'sd58872272;
      5'd3: r = 34'sd29884485;
      5'd4: r = 34'sd15000234;
      5'd5: r = 34'sd7507429;
      5'd6: r = 34'sd3754631;
      5'd7: r = 34'sd1877430;
      5'd8: r = 34'sd938729;
      5'd9: r = 34'sd469366;
      default: r = (DEG_SCALE + (34'sd1 <<< (i - 5'd1))) >>> i;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/rbba_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbba_in_if / rbba_out_if
// Valid/ready channels for box items and bounds results.
// ----------------------------------------------------------------------------
interface rbba_in_if import rbba_pkg::*; ();
  logic   valid;
  logic   ready;
  logic [1:0] cmd;
  coord_t corner_a_x, corner_a_y, corner_a_z;
  coord_t corner_b_x, corner_b_y, corner_b_z;
  coord_t pivot_x, pivot_y, pivot_z;
  logic [1:0] rot_axis;
  angle_t rot_angle;
  modport source (output valid, cmd, corner_a_x, corner_a_y, corner_a_z, corner_b_x,
                  corner_b_y, corner_b_z, pivot_x, pivot_y, pivot_z, rot_axis,
                  rot_angle, input ready);
  modport sink (input valid, cmd, corner_a_x, corner_a_y, corner_a_z, corner_b_x,
                corner_b_y, corner_b_z, pivot_x, pivot_y, pivot_z, rot_axis,
                rot_angle, output ready);
endinterface

interface rbba_out_if import rbba_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t low_x, low_y, low_z, high_x, high_y, high_z;
  logic   found;
  modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z, found,
                  input ready);
  modport sink (input valid, low_x, low_y, low_z, high_x, high_y, high_z, found,
                output ready);
endinterface

// ===== sv/rotated_box_bounds_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_box_bounds_accumulator
// Running axis-aligned bounds over points and rotated boxes.
// ----------------------------------------------------------------------------
// A point or unused command needs no further work after its transfer. A finish
// loads the output register, where the result waits until transferred; while it waits the
// input is held off, unless the result is transferred in that same cycle.
// A box keeps the input held off until its work is done: angle reduction,
// CORDIC_STEPS iterations of one shared shift-add stage, rounding, then for
// each of eight corners four passes through one shared 25x18 multiplier
// followed by a combine and fold step.
module rotated_box_bounds_accumulator import rbba_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  rbba_in_if.sink   in_ch,
  rbba_out_if.source out_ch
);

  localparam int SW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_REDUCE = 7'b0000010,
    ST_CORDIC = 7'b0000100,
    ST_ROUND  = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_FOLD   = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_t;

  state_t state;

  coord_t run_min [3];
  coord_t run_max [3];
  logic   any_seen;

  coord_t lo [3];
  coord_t hi [3];
  coord_t piv [3];
  logic [1:0] axis;
  angle_t angle;

  logic        flip;
  logic signed [33:0] cx, cy, cz;
  logic [SW-1:0] step;
  logic signed [17:0] sn, cs;
  logic [2:0] corner;
  logic [1:0] mcnt;
  logic signed [42:0] prod [4];

  logic out_valid;
  coord_t o_low [3];
  coord_t o_high [3];
  logic o_found;

  assign in_ch.ready = (state == ST_IDLE) && !(out_valid && !out_ch.ready);
  assign out_ch.valid = out_valid;
  assign out_ch.low_x = o_low[0];
  assign out_ch.low_y = o_low[1];
  assign out_ch.low_z = o_low[2];
  assign out_ch.high_x = o_high[0];
  assign out_ch.high_y = o_high[1];
  assign out_ch.high_z = o_high[2];
  assign out_ch.found = o_found;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;

  // angle mod 23040 by repeated subtraction, then folded into [-11520, 11520)
  logic signed [16:0] a_ext;
  logic [16:0] a_off;
  logic [16:0] r0;
  logic signed [17:0] rr;
  always_comb begin
    a_ext = {angle[ANGLE_W-1], angle};
    // angle in [-32768, 32767]; add 46080 to make non-negative, then reduce
    a_off = 17'(a_ext + 17'sd46080);
    r0 = a_off;
    if (r0 >= 17'd23040) r0 = 17'(r0 - 17'd23040);
    if (r0 >= 17'd23040) r0 = 17'(r0 - 17'd23040);
    if (r0 >= 17'd23040) r0 = 17'(r0 - 17'd23040);
    rr = (r0 >= 17'd11520) ? 18'($signed({1'b0, r0}) - 18'sd23040)
                           : 18'($signed({1'b0, r0}));
  end

  // shared CORDIC stage
  logic signed [33:0] dx, dy;
  always_comb begin
    dx = cy >>> step;
    dy = cx >>> step;
  end

  // corner point relative to pivot, selected by the axis pair
  logic signed [24:0] pa, pb;
  logic [1:0] ia, ib;
  always_comb begin
    case (axis)
      AXIS_X: begin ia = 2'd1; ib = 2'd2; end
      AXIS_Y: begin ia = 2'd0; ib = 2'd2; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
    pa = 25'((corner[ia] ? hi[ia] : lo[ia])) - 25'(piv[ia]);
    pb = 25'((corner[ib] ? hi[ib] : lo[ib])) - 25'(piv[ib]);
  end

  // one shared multiplier: pa*c, pb*s, pa*s, pb*c
  logic signed [24:0] m_a;
  logic signed [17:0] m_b;
  always_comb begin
    case (mcnt)
      2'd0: begin m_a = pa; m_b = cs; end
      2'd1: begin m_a = pb; m_b = sn; end
      2'd2: begin m_a = pa; m_b = sn; end
      default: begin m_a = pb; m_b = cs; end
    endcase
  end

  function automatic coord_t comb_sat(input logic signed [43:0] v, input coord_t pv);
    logic signed [27:0] t;
    logic signed [28:0] u;
    t = 28'((v + 44'sd32768) >>> 16);
    u = 29'(t) + 29'(pv);
    if (u > 29'sd8388607) return COORD_MAX;
    if (u < -29'sd8388608) return COORD_MIN;
    return coord_t'(u);
  endfunction

  // rotated point, formula depends on axis
  coord_t q [3];
  coord_t ra, rb;
  always_comb begin
    if (axis == AXIS_Y) begin
      ra = comb_sat(44'(prod[0]) + 44'(prod[1]), piv[ia]);
      rb = comb_sat(44'(prod[3]) - 44'(prod[2]), piv[ib]);
    end else begin
      ra = comb_sat(44'(prod[0]) - 44'(prod[1]), piv[ia]);
      rb = comb_sat(44'(prod[2]) + 44'(prod[3]), piv[ib]);
    end
    for (int k = 0; k < 3; k++) q[k] = corner[k] ? hi[k] : lo[k];
    q[ia] = ra;
    q[ib] = rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      any_seen <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        run_min[k] <= COORD_MAX;
        run_max[k] <= COORD_MIN;
      end
    end else begin
      // drop the result once transferred, unless a finish refills it now
      if (out_valid && out_ch.ready && !(accept && in_ch.cmd == CMD_FINISH))
        out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_t'(in_ch.cmd))
              CMD_BOX: begin
                lo[0] <= (in_ch.corner_a_x < in_ch.corner_b_x) ? in_ch.corner_a_x
                                                               : in_ch.corner_b_x;
                hi[0] <= (in_ch.corner_a_x < in_ch.corner_b_x) ? in_ch.corner_b_x
                                                               : in_ch.corner_a_x;
                lo[1] <= (in_ch.corner_a_y < in_ch.corner_b_y) ? in_ch.corner_a_y
                                                               : in_ch.corner_b_y;
                hi[1] <= (in_ch.corner_a_y < in_ch.corner_b_y) ? in_ch.corner_b_y
                                                               : in_ch.corner_a_y;
                lo[2] <= (in_ch.corner_a_z < in_ch.corner_b_z) ? in_ch.corner_a_z
                                                               : in_ch.corner_b_z;
                hi[2] <= (in_ch.corner_a_z < in_ch.corner_b_z) ? in_ch.corner_b_z
                                                               : in_ch.corner_a_z;
                piv[0] <= in_ch.pivot_x;
                piv[1] <= in_ch.pivot_y;
                piv[2] <= in_ch.pivot_z;
                axis <= in_ch.rot_axis;
                angle <= in_ch.rot_angle;
                state <= ST_REDUCE;
              end
              CMD_POINT: begin
                if (in_ch.corner_a_x < run_min[0]) run_min[0] <= in_ch.corner_a_x;
                if (in_ch.corner_a_x > run_max[0]) run_max[0] <= in_ch.corner_a_x;
                if (in_ch.corner_a_y < run_min[1]) run_min[1] <= in_ch.corner_a_y;
                if (in_ch.corner_a_y > run_max[1]) run_max[1] <= in_ch.corner_a_y;
                if (in_ch.corner_a_z < run_min[2]) run_min[2] <= in_ch.corner_a_z;
                if (in_ch.corner_a_z > run_max[2]) run_max[2] <= in_ch.corner_a_z;
                any_seen <= 1'b1;
              end
              CMD_FINISH: begin
                out_valid <= 1'b1;
                o_found <= any_seen;
                for (int k = 0; k < 3; k++) begin
                  o_low[k] <= any_seen ? run_min[k] : '0;
                  o_high[k] <= any_seen ? run_max[k] : '0;
                  run_min[k] <= COORD_MAX;
                  run_max[k] <= COORD_MIN;
                end
                any_seen <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_REDUCE: begin
          flip <= (rr > 18'sd5760) || (rr < -18'sd5760);
          if (rr > 18'sd5760)
            cz <= 34'(rr - 18'sd11520) <<< 16;
          else if (rr < -18'sd5760)
            cz <= 34'(rr + 18'sd11520) <<< 16;
          else
            cz <= 34'(rr) <<< 16;
          cx <= 34'(INV_GAIN);
          cy <= '0;
          step <= '0;
          state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - atan_entry(5'(step));
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + atan_entry(5'(step));
          end
          if (step == SW'(CORDIC_STEPS - 1)) state <= ST_ROUND;
          step <= SW'(step + 1'b1);
        end
        ST_ROUND: begin
          cs <= flip ? 18'(-((cx + 34'sd8192) >>> 14)) : 18'((cx + 34'sd8192) >>> 14);
          sn <= flip ? 18'(-((cy + 34'sd8192) >>> 14)) : 18'((cy + 34'sd8192) >>> 14);
          corner <= '0;
          mcnt <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod[mcnt] <= 43'(m_a * m_b);
          mcnt <= 2'(mcnt + 1'b1);
          if (mcnt == 2'd3) state <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int k = 0; k < 3; k++) begin
            if (q[k] < run_min[k]) run_min[k] <= q[k];
            if (q[k] > run_max[k]) run_max[k] <= q[k];
          end
          any_seen <= 1'b1;
          corner <= 3'(corner + 1'b1);
          state <= (corner == 3'd7) ? ST_IDLE : ST_MUL;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rbba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbba_checker
// Port-level checks on the bounds accumulator.
// ----------------------------------------------------------------------------
module rbba_checker import rbba_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [1:0] in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic signed [23:0] out_low_x,
  input logic signed [23:0] out_high_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_low_x))
    else $error("result dropped while stalled");

  a_box_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_BOX |=> !in_ready)
    else $error("ready during box work");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_cmd == CMD_FINISH))
    else $error("result without finish");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_found |-> out_low_x <= out_high_x)
    else $error("bounds inverted");

endmodule

bind rotated_box_bounds_accumulator rbba_checker u_rbba_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_found(out_ch.found),
  .out_low_x(out_ch.low_x), .out_high_x(out_ch.high_x)
);
